>>> design/query_language_lexer_defines.svh
// Assertion macros for the query lexer RTL, used by qll_resq.
// No dependencies; the using module must provide clk and arst_n.
`ifndef QUERY_LANGUAGE_LEXER_DEFINES_SVH
`define QUERY_LANGUAGE_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define QLL_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("query lexer: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define QLL_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("query lexer: next-cycle check failed");

`endif

>>> design/qll_pkg.sv
// Types, constants and helper functions for the query lexer.
// No dependencies; used by qll_step, qll_resq and query_language_lexer.
package qll_pkg;

	// Source length limit and the derived position width
	localparam int MAX_SOURCE_LEN = 65536;
	localparam int POS_W = $clog2(MAX_SOURCE_LEN + 1);
	localparam int MAX_RESULTS = 4;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PERIOD = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;

	// Scanner mode between characters
	typedef enum logic [3:0] {
		M_IDLE, M_BANG, M_EQ, M_LT, M_GT, M_INT, M_DOT, M_FRAC,
		M_IDENT, M_STRING, M_DISCARD
	} mode_t;

	// Token kinds
	typedef enum logic [4:0] {
		K_END, K_LPAREN, K_RPAREN, K_COMMA, K_PERIOD, K_SEMICOLON,
		K_MINUS, K_PLUS, K_STAR, K_SLASH, K_BANG, K_NE, K_EQ, K_EQEQ,
		K_LT, K_LE, K_GT, K_GE, K_STRING, K_NUMBER, K_IDENT,
		K_BADCHAR, K_OPENSTR, K_TOOLONG
	} kind_t;

	// Input transaction
	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} src_t;

	// Output transaction
	typedef struct packed {
		kind_t       token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} tok_t;

	// Scanner state
	typedef struct packed {
		mode_t            mode;
		logic [POS_W-1:0] pos;
		logic [15:0]      tok_begin;
	} state_t;

	// Tokens produced by one character, in order
	typedef struct packed {
		logic [2:0]                   count;
		tok_t [MAX_RESULTS-1:0]       item;
	} batch_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
	endfunction

	// Kind of a pending operator, single or with a trailing '='
	function automatic kind_t op_kind(input mode_t m, input logic two);
		kind_t k;
		case (m)
			M_BANG:  k = two ? K_NE : K_BANG;
			M_EQ:    k = two ? K_EQEQ : K_EQ;
			M_LT:    k = two ? K_LE : K_LT;
			default: k = two ? K_GE : K_GT;
		endcase
		return k;
	endfunction

endpackage

>>> design/qll_step.sv
// Next-state and token logic for one source character of the query lexer.
// Depends on qll_pkg.
module qll_step (
	input  qll_pkg::state_t cur,
	input  qll_pkg::src_t   data,
	output qll_pkg::state_t nxt,
	output qll_pkg::batch_t batch
);

	localparam logic [qll_pkg::POS_W-1:0] MAX_POS =
		qll_pkg::POS_W'(qll_pkg::MAX_SOURCE_LEN);
	localparam logic [15:0] MAX_START = 16'(qll_pkg::MAX_SOURCE_LEN);

	logic [15:0]     p16;
	logic [15:0]     p16_m1;
	logic [15:0]     np16;
	logic            idle_scan;
	logic            err;
	logic            dig;
	logic            alp;
	qll_pkg::state_t st;
	qll_pkg::batch_t b;

	// Append one token to a batch, saturating at the batch size
	function automatic qll_pkg::batch_t push(input qll_pkg::batch_t bi,
			input qll_pkg::kind_t k, input logic [15:0] s, input logic [15:0] l);
		qll_pkg::batch_t bo;
		bo = bi;
		if (bi.count < 3'(qll_pkg::MAX_RESULTS)) begin
			bo.item[bi.count[1:0]] = '{token_kind: k, token_start: s,
				token_length: l, last_of_run: 1'b0};
			bo.count = bi.count + 3'd1;
		end
		return bo;
	endfunction

	assign dig = qll_pkg::is_digit(data.ch);
	assign alp = qll_pkg::is_alpha(data.ch);

	// Character step, then end-of-source flush
	always_comb begin
		st        = cur;
		b         = '0;
		err       = 1'b0;
		idle_scan = 1'b0;
		p16       = 16'(cur.pos);
		p16_m1    = p16 - 16'd1;
		np16      = '0;

		if (cur.mode == qll_pkg::M_DISCARD) begin
			err = 1'b1;
		end else if (cur.pos >= MAX_POS) begin
			b       = push(b, qll_pkg::K_TOOLONG, MAX_START, 16'd0);
			st.mode = qll_pkg::M_DISCARD;
			err     = 1'b1;
		end else begin
			// finish or extend the pending token
			case (cur.mode)
				qll_pkg::M_BANG, qll_pkg::M_EQ, qll_pkg::M_LT, qll_pkg::M_GT: begin
					st.mode = qll_pkg::M_IDLE;
					if (data.ch == qll_pkg::CH_EQ) begin
						b = push(b, qll_pkg::op_kind(cur.mode, 1'b1), cur.tok_begin, 16'd2);
					end else begin
						b = push(b, qll_pkg::op_kind(cur.mode, 1'b0), cur.tok_begin, 16'd1);
						idle_scan = 1'b1;
					end
				end
				qll_pkg::M_INT: begin
					if (data.ch == qll_pkg::CH_PERIOD) begin
						st.mode = qll_pkg::M_DOT;
					end else if (!dig) begin
						st.mode   = qll_pkg::M_IDLE;
						b         = push(b, qll_pkg::K_NUMBER, cur.tok_begin, p16 - cur.tok_begin);
						idle_scan = 1'b1;
					end
				end
				qll_pkg::M_DOT: begin
					if (dig) begin
						st.mode = qll_pkg::M_FRAC;
					end else begin
						st.mode   = qll_pkg::M_IDLE;
						b         = push(b, qll_pkg::K_NUMBER, cur.tok_begin, p16_m1 - cur.tok_begin);
						b         = push(b, qll_pkg::K_PERIOD, p16_m1, 16'd1);
						idle_scan = 1'b1;
					end
				end
				qll_pkg::M_FRAC: begin
					if (!dig) begin
						st.mode   = qll_pkg::M_IDLE;
						b         = push(b, qll_pkg::K_NUMBER, cur.tok_begin, p16 - cur.tok_begin);
						idle_scan = 1'b1;
					end
				end
				qll_pkg::M_IDENT: begin
					if (!dig && !alp) begin
						st.mode   = qll_pkg::M_IDLE;
						b         = push(b, qll_pkg::K_IDENT, cur.tok_begin, p16 - cur.tok_begin);
						idle_scan = 1'b1;
					end
				end
				qll_pkg::M_STRING: begin
					if (data.ch == qll_pkg::CH_DQUOTE) begin
						st.mode = qll_pkg::M_IDLE;
						b       = push(b, qll_pkg::K_STRING, cur.tok_begin, p16 - cur.tok_begin);
					end
				end
				default: begin
					st.mode   = qll_pkg::M_IDLE;
					idle_scan = 1'b1;
				end
			endcase

			// start a new token from an idle scanner
			if (idle_scan) begin
				case (data.ch)
					qll_pkg::CH_SPACE, qll_pkg::CH_TAB, qll_pkg::CH_CR, qll_pkg::CH_LF: begin
						st.mode = qll_pkg::M_IDLE;
					end
					qll_pkg::CH_LPAREN: b = push(b, qll_pkg::K_LPAREN, p16, 16'd1);
					qll_pkg::CH_RPAREN: b = push(b, qll_pkg::K_RPAREN, p16, 16'd1);
					qll_pkg::CH_COMMA:  b = push(b, qll_pkg::K_COMMA, p16, 16'd1);
					qll_pkg::CH_PERIOD: b = push(b, qll_pkg::K_PERIOD, p16, 16'd1);
					qll_pkg::CH_SEMI:   b = push(b, qll_pkg::K_SEMICOLON, p16, 16'd1);
					qll_pkg::CH_MINUS:  b = push(b, qll_pkg::K_MINUS, p16, 16'd1);
					qll_pkg::CH_PLUS:   b = push(b, qll_pkg::K_PLUS, p16, 16'd1);
					qll_pkg::CH_STAR:   b = push(b, qll_pkg::K_STAR, p16, 16'd1);
					qll_pkg::CH_SLASH:  b = push(b, qll_pkg::K_SLASH, p16, 16'd1);
					qll_pkg::CH_BANG: begin
						st.mode      = qll_pkg::M_BANG;
						st.tok_begin = p16;
					end
					qll_pkg::CH_EQ: begin
						st.mode      = qll_pkg::M_EQ;
						st.tok_begin = p16;
					end
					qll_pkg::CH_LT: begin
						st.mode      = qll_pkg::M_LT;
						st.tok_begin = p16;
					end
					qll_pkg::CH_GT: begin
						st.mode      = qll_pkg::M_GT;
						st.tok_begin = p16;
					end
					qll_pkg::CH_DQUOTE: begin
						st.mode      = qll_pkg::M_STRING;
						st.tok_begin = p16 + 16'd1;
					end
					default: begin
						if (dig) begin
							st.mode      = qll_pkg::M_INT;
							st.tok_begin = p16;
						end else if (alp) begin
							st.mode      = qll_pkg::M_IDENT;
							st.tok_begin = p16;
						end else begin
							b       = push(b, qll_pkg::K_BADCHAR, p16, 16'd1);
							st.mode = qll_pkg::M_DISCARD;
						end
					end
				endcase
			end

			if (st.mode == qll_pkg::M_DISCARD) begin
				err = 1'b1;
			end
			st.pos = cur.pos + qll_pkg::POS_W'(1);
		end

		// end of source: flush the pending token, close, back to reset
		if (data.end_of_source) begin
			np16 = 16'(st.pos);
			if (!err) begin
				case (st.mode)
					qll_pkg::M_BANG, qll_pkg::M_EQ, qll_pkg::M_LT, qll_pkg::M_GT:
						b = push(b, qll_pkg::op_kind(st.mode, 1'b0), st.tok_begin, 16'd1);
					qll_pkg::M_INT, qll_pkg::M_FRAC:
						b = push(b, qll_pkg::K_NUMBER, st.tok_begin, np16 - st.tok_begin);
					qll_pkg::M_IDENT:
						b = push(b, qll_pkg::K_IDENT, st.tok_begin, np16 - st.tok_begin);
					qll_pkg::M_DOT: begin
						b = push(b, qll_pkg::K_NUMBER, st.tok_begin,
							np16 - 16'd1 - st.tok_begin);
						b = push(b, qll_pkg::K_PERIOD, np16 - 16'd1, 16'd1);
					end
					qll_pkg::M_STRING: begin
						b   = push(b, qll_pkg::K_OPENSTR, st.tok_begin, np16 - st.tok_begin);
						err = 1'b1;
					end
					default: begin
						err = 1'b0;
					end
				endcase
				if (!err) begin
					b = push(b, qll_pkg::K_END, np16, 16'd0);
				end
			end
			st.mode      = qll_pkg::M_IDLE;
			st.pos       = '0;
			st.tok_begin = '0;
		end

		// flag the final token of this character
		if (b.count != 3'd0) begin
			b.item[b.count[1:0] - 2'd1].last_of_run = 1'b1;
		end

		nxt   = st;
		batch = b;
	end

endmodule

>>> design/qll_resq.sv
// Result register bank of the query lexer: holds one character's tokens
// and hands them out one per cycle while tok_ready is high. Depends on qll_pkg, defines header.
`include "query_language_lexer_defines.svh"

module qll_resq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  qll_pkg::batch_t batch,
	output logic            space,
	output logic            tok_valid,
	input  logic            tok_ready,
	output qll_pkg::tok_t   tok_data
);

	logic [2:0]                            rem_q;
	qll_pkg::tok_t [qll_pkg::MAX_RESULTS-1:0] item_q;
	logic                                  pop;

	// free once the last held token leaves this cycle
	assign pop       = (rem_q != 3'd0) && tok_ready;
	assign space     = (rem_q == 3'd0) || ((rem_q == 3'd1) && tok_ready);
	assign tok_valid = (rem_q != 3'd0);
	assign tok_data  = item_q[0];

	// count of tokens still to deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= batch.count;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// token slots: load a batch, shift down on each transaction
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= batch.item;
		end else if (pop) begin
			item_q[qll_pkg::MAX_RESULTS-2:0] <= item_q[qll_pkg::MAX_RESULTS-1:1];
		end
	end

	`QLL_ASSERT_IMP(a_rem_bound, 1'b1, rem_q <= 3'(qll_pkg::MAX_RESULTS))
	`QLL_ASSERT_IMP(a_load_space, load, (rem_q == 3'd0) || ((rem_q == 3'd1) && tok_ready))
	`QLL_ASSERT_NEXT(a_load_count, load, (rem_q == $past(batch.count)) && (rem_q != 3'd0))
	`QLL_ASSERT_IMP(a_tail_marked, rem_q == 3'd1, item_q[0].last_of_run)

endmodule

>>> design/query_language_lexer.sv
// Query text lexer: source bytes in, tokens (kind, start, length) out.
// Depends on qll_pkg, qll_step and qll_resq.
//
// Usage:
//  src channel (src_valid/src_ready/src_data) takes one byte per transaction
//  with end_of_source set on the final byte of a source text.
//  tok channel (tok_valid/tok_ready/tok_data) gives tokens in source order;
//  last_of_run marks the final token caused by one byte.
//  Path: a byte is registered in the input stage, then its tokens are
//  registered in the result bank, which drives tok_data.
//  Throughput: one byte per cycle while tok_ready is high and each byte
//  yields at most one token; up to four tokens per byte. A byte yielding
//  more keeps the result bank busy, so the byte behind it waits.
//  When the receiver stalls, the result bank holds its tokens and the input
//  stage holds one more byte; src_ready drops while its tokens cannot fit.
//  Reset clears the scanner to idle at position zero with nothing pending;
//  the same happens after every byte marked end_of_source.
//  After an error token, bytes are dropped until end_of_source.
module query_language_lexer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_ready,
	input  qll_pkg::src_t  src_data,
	output logic           tok_valid,
	input  logic           tok_ready,
	output qll_pkg::tok_t  tok_data
);

	logic            valid_s1;
	qll_pkg::src_t   data_s1;
	qll_pkg::state_t state_q;
	qll_pkg::state_t state_d;
	qll_pkg::batch_t batch;
	logic            space;
	logic            fire;
	logic            load;

	// byte in stage 1 is consumed once its tokens fit in the result bank
	assign fire      = valid_s1 && ((batch.count == 3'd0) || space);
	assign load      = fire && (batch.count != 3'd0);
	assign src_ready = !valid_s1 || fire;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && src_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			data_s1 <= src_data;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: qll_pkg::M_IDLE, pos: '0, tok_begin: '0};
		end else if (fire) begin
			state_q <= state_d;
		end
	end

	qll_step u_step (
		.cur   (state_q),
		.data  (data_s1),
		.nxt   (state_d),
		.batch (batch)
	);

	qll_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.batch     (batch),
		.space     (space),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

endmodule

>>> tb/query_language_lexer_test.sv
`timescale 1ns / 100ps
// Self-checking bench for query_language_lexer: drives source bytes and checks every token.
// Depends on qll_pkg for the transaction types, the scanner modes and the token kinds.
module query_language_lexer_test;
	import qll_pkg::*;

	// Shadow scanner: predicts the tokens each byte causes and matches them as they leave
	class token_tracker;
		tok_t        tokens_due[$];
		tok_t        run[$];
		mode_t       mode;
		int unsigned pos;
		int unsigned tok_begin;
		int unsigned errors;
		int unsigned checked;

		function new();
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			mode = M_IDLE;
			pos = 0;
			tok_begin = 0;
		endfunction

		function bit is_num(logic [7:0] c);
			return (c >= "0") && (c <= "9");
		endfunction

		function bit is_letter(logic [7:0] c);
			return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
		endfunction

		// Single-character kind of a pending operator; the '=' form is the next kind up
		function kind_t lone_op(mode_t m);
			case (m)
				M_BANG:  return K_BANG;
				M_EQ:    return K_EQ;
				M_LT:    return K_LT;
				default: return K_GT;
			endcase
		endfunction

		// At most four tokens per byte; positions and lengths wrap to 16 bits
		function void push_token(kind_t k, int unsigned start, int unsigned len);
			tok_t t;
			if (run.size() >= MAX_RESULTS)
				return;
			t.token_kind   = k;
			t.token_start  = start[15:0];
			t.token_length = len[15:0];
			t.last_of_run  = 1'b0;
			run.insert(run.size(), t);
		endfunction

		// Character seen with nothing pending
		function void begin_token(logic [7:0] c, int unsigned p);
			kind_t k;
			bit    sym;
			k = K_END;
			sym = 1'b1;
			case (c)
				CH_SPACE, CH_TAB, CH_CR, CH_LF: sym = 1'b0;
				CH_LPAREN: k = K_LPAREN;
				CH_RPAREN: k = K_RPAREN;
				CH_COMMA:  k = K_COMMA;
				CH_PERIOD: k = K_PERIOD;
				CH_SEMI:   k = K_SEMICOLON;
				CH_MINUS:  k = K_MINUS;
				CH_PLUS:   k = K_PLUS;
				CH_STAR:   k = K_STAR;
				CH_SLASH:  k = K_SLASH;
				CH_BANG: begin
					mode = M_BANG; tok_begin = p; sym = 1'b0;
				end
				CH_EQ: begin
					mode = M_EQ; tok_begin = p; sym = 1'b0;
				end
				CH_LT: begin
					mode = M_LT; tok_begin = p; sym = 1'b0;
				end
				CH_GT: begin
					mode = M_GT; tok_begin = p; sym = 1'b0;
				end
				CH_DQUOTE: begin
					mode = M_STRING; tok_begin = p + 1; sym = 1'b0;
				end
				default: begin
					sym = 1'b0;
					tok_begin = p;
					if (is_num(c))
						mode = M_INT;
					else if (is_letter(c))
						mode = M_IDENT;
					else begin
						push_token(K_BADCHAR, p, 1);
						mode = M_DISCARD;
					end
				end
			endcase
			if (sym)
				push_token(k, p, 1);
		endfunction

		// Pending token ends at p; the terminating character is then scanned afresh
		function void close_token(kind_t k, logic [7:0] c, int unsigned p);
			mode = M_IDLE;
			push_token(k, tok_begin, p - tok_begin);
			begin_token(c, p);
		endfunction

		// Accepted source transaction: work out its tokens and queue them
		function void scan_byte(src_t s);
			logic [7:0]  c;
			int unsigned p;
			bit          failed;
			mode_t       m;
			tok_t        t;
			c = s.ch;
			p = pos;
			failed = 1'b0;
			run.delete();
			if (mode == M_DISCARD)
				failed = 1'b1;
			else if (p >= MAX_SOURCE_LEN) begin
				// pending token is dropped
				push_token(K_TOOLONG, MAX_SOURCE_LEN, 0);
				mode = M_DISCARD;
				failed = 1'b1;
			end else begin
				m = mode;
				case (m)
					M_BANG, M_EQ, M_LT, M_GT: begin
						mode = M_IDLE;
						if (c == CH_EQ)
							push_token(kind_t'(lone_op(m) + 1), tok_begin, 2);
						else begin
							push_token(lone_op(m), tok_begin, 1);
							begin_token(c, p);
						end
					end
					M_INT: begin
						if (c == CH_PERIOD)
							mode = M_DOT;
						else if (!is_num(c))
							close_token(K_NUMBER, c, p);
					end
					M_DOT: begin
						// period not followed by a digit leaves the number
						if (is_num(c))
							mode = M_FRAC;
						else begin
							mode = M_IDLE;
							push_token(K_NUMBER, tok_begin, p - 1 - tok_begin);
							push_token(K_PERIOD, p - 1, 1);
							begin_token(c, p);
						end
					end
					M_FRAC: begin
						if (!is_num(c))
							close_token(K_NUMBER, c, p);
					end
					M_IDENT: begin
						if (!is_num(c) && !is_letter(c))
							close_token(K_IDENT, c, p);
					end
					M_STRING: begin
						if (c == CH_DQUOTE) begin
							mode = M_IDLE;
							push_token(K_STRING, tok_begin, p - tok_begin);
						end
					end
					default: begin
						mode = M_IDLE;
						begin_token(c, p);
					end
				endcase
				if (mode == M_DISCARD)
					failed = 1'b1;
				pos = p + 1;
			end

			// End of source: flush the pending token, then the end token unless in error
			if (s.end_of_source) begin
				if (!failed) begin
					case (mode)
						M_BANG, M_EQ, M_LT, M_GT: push_token(lone_op(mode), tok_begin, 1);
						M_INT, M_FRAC: push_token(K_NUMBER, tok_begin, pos - tok_begin);
						M_IDENT: push_token(K_IDENT, tok_begin, pos - tok_begin);
						M_DOT: begin
							push_token(K_NUMBER, tok_begin, pos - 1 - tok_begin);
							push_token(K_PERIOD, pos - 1, 1);
						end
						M_STRING: begin
							push_token(K_OPENSTR, tok_begin, pos - tok_begin);
							failed = 1'b1;
						end
						default: ;
					endcase
					if (!failed)
						push_token(K_END, pos, 0);
				end
				restart();
			end

			if (run.size() > 0) begin
				t = run[run.size() - 1];
				t.last_of_run = 1'b1;
				run[run.size() - 1] = t;
			end
			foreach (run[i])
				tokens_due.insert(tokens_due.size(), run[i]);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Accepted token transaction against the oldest prediction
		task check_token(tok_t got);
			tok_t want;
			checked++;
			if (tokens_due.size() == 0) begin
				report($sformatf("unexpected token kind %0d start %0d length %0d",
					got.token_kind, got.token_start, got.token_length));
				return;
			end
			want = tokens_due.pop_front();
			if (got.token_kind !== want.token_kind)
				report($sformatf("token %0d kind %0d, want %0d",
					checked, got.token_kind, want.token_kind));
			if (got.token_start !== want.token_start)
				report($sformatf("token %0d start %0d, want %0d",
					checked, got.token_start, want.token_start));
			if (got.token_length !== want.token_length)
				report($sformatf("token %0d length %0d, want %0d",
					checked, got.token_length, want.token_length));
			if (got.last_of_run !== want.last_of_run)
				report($sformatf("token %0d last_of_run %0b, want %0b",
					checked, got.last_of_run, want.last_of_run));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	src_t src_data;
	logic tok_valid;
	logic tok_ready;
	tok_t tok_data;

	token_tracker tracker;
	bit           quiet;
	int unsigned  bytes_sent;
	int unsigned  sources_sent;

	query_language_lexer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous ceiling on run time
	initial begin
		#10_000_000;
		$display("[query_language_lexer] ERROR");
		$finish;
	end

	// Receiver: random back-pressure except in the quiet stretch
	always @(negedge clk)
		tok_ready <= quiet || ($urandom_range(0, 99) >= 9);

	// Token monitor
	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready)
			tracker.check_token(tok_data);
	end

	// One source transaction; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] c, input logic last);
		src_t item;
		item.ch = c;
		item.end_of_source = last;
		while (!quiet && $urandom_range(0, 99) < 9) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_data <= item;
		do @(posedge clk); while (!src_ready);
		tracker.scan_byte(item);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_source(input byte unsigned text[$]);
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
		sources_sent++;
	endtask

	function automatic void append_byte(ref byte unsigned text[$], input byte unsigned b);
		text.insert(text.size(), b);
	endfunction

	function automatic void add_text(ref byte unsigned text[$], input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(text, s[i]);
	endfunction

	function automatic byte unsigned rand_letter();
		if ($urandom_range(0, 1))
			return 8'(8'h61 + $urandom_range(0, 25));
		return 8'(8'h41 + $urandom_range(0, 25));
	endfunction

	function automatic byte unsigned rand_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	// Random query-like text: mostly well-formed tokens, some adjacency and noise
	function automatic void build_source(ref byte unsigned text[$]);
		byte unsigned ops[13];
		byte unsigned spaces[4];
		byte unsigned b;
		int           pick;
		ops = '{CH_LPAREN, CH_RPAREN, CH_COMMA, CH_PERIOD, CH_SEMI, CH_MINUS, CH_PLUS,
			CH_STAR, CH_SLASH, CH_BANG, CH_EQ, CH_LT, CH_GT};
		spaces = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
		repeat ($urandom_range(1, 10)) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				append_byte(text, rand_letter());
				repeat ($urandom_range(0, 6))
					append_byte(text, $urandom_range(0, 2) ? rand_letter() : rand_digit());
			end else if (pick < 45) begin
				repeat ($urandom_range(1, 4))
					append_byte(text, rand_digit());
				case ($urandom_range(0, 3))
					0: begin
						append_byte(text, CH_PERIOD);
						repeat ($urandom_range(1, 3))
							append_byte(text, rand_digit());
					end
					1: append_byte(text, CH_PERIOD);
					default: ;
				endcase
			end else if (pick < 60) begin
				append_byte(text, CH_DQUOTE);
				repeat ($urandom_range(0, 5)) begin
					b = 8'($urandom_range(0, 255));
					append_byte(text, b == CH_DQUOTE ? CH_SPACE : b);
				end
				if ($urandom_range(0, 5) != 0)
					append_byte(text, CH_DQUOTE);
			end else if (pick < 82) begin
				append_byte(text, ops[$urandom_range(0, 12)]);
				if ($urandom_range(0, 2) == 0)
					append_byte(text, CH_EQ);
			end else if (pick < 96) begin
				repeat ($urandom_range(1, 2))
					append_byte(text, spaces[$urandom_range(0, 3)]);
			end else
				append_byte(text, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				append_byte(text, spaces[$urandom_range(0, 3)]);
		end
	endfunction

	// Main sequence
	initial begin
		byte unsigned text[$];
		int unsigned  rand_bytes;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_data = '0;
		tok_ready = 1'b0;
		quiet = 1'b0;
		bytes_sent = 0;
		sources_sent = 0;
		rand_bytes = 0;
		tracker = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every symbol and operator, a four-token byte, open string, bad bytes
		text = {}; add_text(text, "(),.;-+*/!!====<<=>>="); send_source(text);
		text = {}; add_text(text, "5.<"); send_source(text);
		text = {}; add_text(text, "7.\t\"q"); send_source(text);
		text = {8'hff}; send_source(text);
		text = {8'h00}; send_source(text);

		// Random sources, with a stretch free of idling on either side
		while (rand_bytes < 195) begin
			quiet = (rand_bytes >= 60) && (rand_bytes < 130);
			text = {};
			build_source(text);
			send_source(text);
			rand_bytes += text.size();
		end
		quiet = 1'b0;

		// Short source to close: two-character operator between identifier and number
		text = {}; add_text(text, "x>=1"); send_source(text);

		src_valid <= 1'b0;
		while (tracker.tokens_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run: %0d sources, %0d bytes, %0d tokens checked, %0d mismatches",
			sources_sent, bytes_sent, tracker.checked, tracker.errors);
		if (tracker.errors == 0)
			$display("[query_language_lexer] OK");
		else
			$display("[query_language_lexer] ERROR");
		$finish;
	end

endmodule

>>> query_language_lexer.f
+incdir+design
design/qll_pkg.sv
design/qll_step.sv
design/qll_resq.sv
design/query_language_lexer.sv
tb/query_language_lexer_test.sv
